@@ src/b2da_pkg.sv @@
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

    // Width of one BCD digit.
    localparam int DIGIT_BITS = 4;

    // Character codes as they leave the datapath, six bits wide.
    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the input word and clear the BCD register
        logic shift;  // one double-dabble step
        logic prep;   // count the significant digits
        logic emit;   // put the next character into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register can take a character this cycle
        logic final_char;  // the next character is the last one of the number
    } status_t;

endpackage

@@ src/b2da_ctrl.sv @@
// Controller state machine: sequences load, conversion, digit count and emission.
module b2da_ctrl #(
    parameter int WORD_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  b2da_pkg::status_t status,
    output b2da_pkg::cmd_t    cmd
);

    localparam int CW = $clog2(WORD_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // State and bit counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = CW'(WORD_BITS - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_PREP;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.final_char) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/b2da_datapath.sv @@
// Datapath: magnitude shifter, double-dabble BCD register, digit selection
// and the output register.
module b2da_datapath #(
    parameter int WORD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  b2da_pkg::cmd_t       cmd,
    output b2da_pkg::status_t    status,
    input  logic [WORD_BITS-1:0] in_word,
    input  logic                 in_unsigned,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [5:0]           out_char,
    output logic                 out_last,
    output logic [3:0]           out_count
);

    // Enough decimal digits for 2^WORD_BITS - 1.
    localparam int NDIG = (WORD_BITS * 30103) / 100000 + 1;
    localparam int BW   = NDIG * b2da_pkg::DIGIT_BITS;
    localparam int IW   = $clog2(NDIG);
    localparam int TW   = $clog2(NDIG + 2);

    logic [WORD_BITS-1:0] mag_reg;
    logic [BW-1:0]        bcd_reg;
    logic                 neg_reg;
    logic                 sign_pend_reg;
    logic [IW-1:0]        idx_reg;
    logic [TW-1:0]        total_reg;
    logic                 out_valid_reg;
    logic [5:0]           out_char_reg;
    logic                 out_last_reg;
    logic [3:0]           out_count_reg;

    logic                 in_neg;
    logic [WORD_BITS-1:0] in_mag;
    logic [BW-1:0]        bcd_adj;
    logic [IW-1:0]        top_idx;
    logic [3:0]           digit_sel;
    logic [TW+3:0]        total_ext;
    logic                 out_free;

    // Sign and magnitude of the incoming word; the most negative value
    // negates to itself, which is its correct unsigned magnitude.
    assign in_neg = !in_unsigned && in_word[WORD_BITS-1];
    assign in_mag = in_neg ? (~in_word + 1'b1) : in_word;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (bcd_reg[d*4 +: 4] >= 4'd5) begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    // Position of the highest nonzero digit, zero when the value is zero.
    always_comb begin
        top_idx = '0;
        for (int d = 1; d < NDIG; d++) begin
            if (bcd_reg[d*4 +: 4] != 4'd0) begin
                top_idx = IW'(d);
            end
        end
    end

    assign digit_sel = bcd_reg[idx_reg*4 +: 4];
    assign total_ext = {4'b0000, total_reg};
    assign out_free  = !out_valid_reg || out_ready;

    assign status.out_free   = out_free;
    assign status.final_char = !sign_pend_reg && (idx_reg == '0);

    // Conversion registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sign_pend_reg <= 1'b0;
        end else if (cmd.prep) begin
            sign_pend_reg <= neg_reg;
        end else if (cmd.emit && sign_pend_reg) begin
            sign_pend_reg <= 1'b0;
        end
        if (cmd.load) begin
            mag_reg <= in_mag;
            neg_reg <= in_neg;
            bcd_reg <= '0;
        end else if (cmd.shift) begin
            mag_reg <= {mag_reg[WORD_BITS-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BW-2:0], mag_reg[WORD_BITS-1]};
        end
        if (cmd.prep) begin
            idx_reg   <= top_idx;
            total_reg <= TW'(top_idx) + TW'(1) + TW'(neg_reg);
        end else if (cmd.emit && !sign_pend_reg && (idx_reg != '0)) begin
            idx_reg <= idx_reg - 1'b1;
        end
    end

    // Output register: holds one character until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            if (sign_pend_reg) begin
                out_char_reg  <= b2da_pkg::CHAR_MINUS;
                out_last_reg  <= 1'b0;
                out_count_reg <= 4'd0;
            end else begin
                out_char_reg  <= b2da_pkg::CHAR_ZERO + {2'b00, digit_sel};
                out_last_reg  <= (idx_reg == '0);
                out_count_reg <= (idx_reg == '0) ? total_ext[3:0] : 4'd0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_count = out_count_reg;

endmodule

@@ src/binary_to_decimal_ascii.sv @@
// Top level of the binary to decimal ASCII converter.
//
// The slave channel takes one number per transaction: s_axis_tdata carries
// the value word, s_axis_tuser says whether it is unsigned. The master
// channel returns the decimal characters, most significant first, one per
// transaction; a negative signed value starts with a minus sign. The final
// character has m_axis_tlast set and the total character count in
// m_axis_tuser; earlier characters carry a count of zero.
// One number at a time is converted. After acceptance the double-dabble
// datapath shifts one bit per cycle through all WORD_BITS bits, a prep step
// then counts the significant digits, and then one character per cycle
// enters the output register while the receiver keeps up. s_axis_tready is
// high again once the last character is in the output register, even while
// it waits to be taken. When the receiver stalls, the current character
// holds and emission pauses. Synchronous reset empties the output register
// and returns to idle.
module binary_to_decimal_ascii #(
    parameter int WORD_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // value_word in the low WORD_BITS bits, zero padding above
    input  logic [((WORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // is_unsigned
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // char_code in bits 5:0, zero in bits 7:6
    output logic [7:0]                       m_axis_tdata,
    output logic                             m_axis_tlast,
    // char_count
    output logic [3:0]                       m_axis_tuser
);

    b2da_pkg::cmd_t    cmd;
    b2da_pkg::status_t status;
    logic [5:0]        char_code;

    b2da_ctrl #(
        .WORD_BITS(WORD_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    b2da_datapath #(
        .WORD_BITS(WORD_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_word     (s_axis_tdata[WORD_BITS-1:0]),
        .in_unsigned (s_axis_tuser),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_char    (char_code),
        .out_last    (m_axis_tlast),
        .out_count   (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, char_code};

endmodule

@@ src/b2da_checker.sv @@
// Port-level checks for the converter and the bind that attaches them.
module b2da_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [((WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [7:0]                     m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic [3:0]                     m_axis_tuser
);

    // A stalled character holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled character changed");

    // A number that waits for acceptance holds its value.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("waiting number changed");

    // A new number is not taken in the cycle after one was accepted.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while converting");

    // Only the last character of a number carries a count.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != 4'd0)))
        else $error("character count on wrong character");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind binary_to_decimal_ascii b2da_checker #(
    .WORD_BITS(WORD_BITS)
) u_b2da_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

@@ test/b2da_char_checker.sv @@
// Checker for the decimal ASCII converter: predicts each number's characters and compares them.
module b2da_char_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // value_word in bits 31:0
    input  logic [31:0] s_axis_tdata,
    // is_unsigned
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // char_code in bits 5:0, zero in bits 7:6
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    // char_count
    input  logic [3:0]  m_axis_tuser,
    output int          error_count,
    output int          chars_pending,
    output int          numbers_seen,
    output int          chars_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] RADIX      = 32'd10;
    localparam int          MAX_DIGITS = 10;

    // One character as it should leave the block.
    typedef struct packed {
        logic [5:0] code;
        logic       last;
        logic [3:0] count;
    } dec_char_t;

    dec_char_t expected_chars[$];

    initial begin
        error_count   = 0;
        chars_pending = 0;
        numbers_seen  = 0;
        chars_seen    = 0;
    end

    // Append the characters of one number, sign first, then digits from the top.
    task automatic predict_decimal(input logic [31:0] word, input logic is_unsigned);
        logic       negative;
        logic [31:0] magnitude;
        logic [3:0] digits [MAX_DIGITS];
        int         n_digits;
        int         total;
        dec_char_t  ch;
        negative  = !is_unsigned && word[31];
        // The most negative value maps onto itself, which is the right unsigned magnitude.
        magnitude = negative ? (~word + 32'd1) : word;
        n_digits  = 0;
        do begin
            digits[n_digits] = 4'(magnitude % RADIX);
            magnitude        = magnitude / RADIX;
            n_digits++;
        end while (magnitude != 0);
        total = n_digits + (negative ? 1 : 0);
        if (negative) begin
            ch.code  = b2da_pkg::CHAR_MINUS;
            ch.last  = 1'b0;
            ch.count = 4'd0;
            expected_chars.push_back(ch);
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            ch.code  = b2da_pkg::CHAR_ZERO + 6'(digits[i]);
            ch.last  = (i == 0);
            ch.count = (i == 0) ? 4'(total) : 4'd0;
            expected_chars.push_back(ch);
        end
    endtask

    // Watch both channels at each edge; values seen here are those before the edge.
    always @(posedge aclk) begin
        dec_char_t want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_decimal(s_axis_tdata, s_axis_tuser);
                numbers_seen++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character transaction tdata=%0d tlast=%0b tuser=%0d",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    error_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== {2'b00, want.code}) begin
                        $display("%0t: char_code mismatch expected %0d actual %0d",
                                 $time, want.code, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $display("%0t: last_char mismatch expected %0b actual %0b",
                                 $time, want.last, m_axis_tlast);
                        error_count++;
                    end
                    if (m_axis_tuser !== want.count) begin
                        $display("%0t: char_count mismatch expected %0d actual %0d",
                                 $time, want.count, m_axis_tuser);
                        error_count++;
                    end
                end
            end
            chars_pending = expected_chars.size();
        end
    end

endmodule

@@ test/binary_to_decimal_ascii_tb.sv @@
// Testbench top for the decimal ASCII converter: clock, reset, stimulus and verdict.
module binary_to_decimal_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_NUMBERS = 400;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int IDLE_PERCENT   = 18;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // value_word in bits 31:0
    logic [31:0] s_axis_tdata  = '0;
    // is_unsigned
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // char_code in bits 5:0, zero in bits 7:6
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    // char_count
    logic [3:0]  m_axis_tuser;

    int error_count;
    int chars_pending;
    int numbers_seen;
    int chars_seen;
    int cycle_count = 0;
    bit steady_phase = 1'b0;

    // Corner values: bit 32 is the unsigned flag, bits 31:0 the word.
    logic [32:0] corner_numbers [$] = '{
        {1'b0, 32'h0000_0000}, {1'b1, 32'h0000_0000},
        {1'b0, 32'h0000_0001}, {1'b1, 32'h0000_0009},
        {1'b0, 32'h0000_000A}, {1'b1, 32'h0000_0063},
        {1'b0, 32'h0000_0064}, {1'b0, 32'hFFFF_FFFF},
        {1'b1, 32'hFFFF_FFFF}, {1'b0, 32'h8000_0000},
        {1'b1, 32'h8000_0000}, {1'b0, 32'h7FFF_FFFF},
        {1'b1, 32'h7FFF_FFFF}, {1'b0, 32'hFFFF_FFF6},
        {1'b0, 32'h8000_0001}, {1'b1, 32'd999999999},
        {1'b1, 32'd1000000000}, {1'b0, 32'hAAAA_AAAA},
        {1'b1, 32'h5555_5555}, {1'b1, 32'hAAAA_AAAA}
    };

    binary_to_decimal_ascii #(
        .WORD_BITS(32)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    b2da_char_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .chars_pending (chars_pending),
        .numbers_seen  (numbers_seen),
        .chars_seen    (chars_seen)
    );

    // Free-running clock.
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Receiver backpressure, switched off during the steady phase.
    always @(posedge aclk) begin
        m_axis_tready <= steady_phase || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one number and hold it until the transaction completes.
    task automatic send_number(input logic [31:0] word, input logic is_unsigned);
        while (!steady_phase && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= is_unsigned;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Stop sending and let every outstanding character come back.
    task automatic drain_outstanding();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait (chars_pending == 0);
    endtask

    // Stimulus and verdict.
    initial begin
        logic [31:0] word;
        logic [31:0] decade;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corner values.
        foreach (corner_numbers[i]) begin
            send_number(corner_numbers[i][31:0], corner_numbers[i][32]);
        end
        drain_outstanding();

        // Random values, with a steady stretch and a few full drains.
        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            steady_phase = (n >= 150 && n < 250);
            case ($urandom_range(5))
                0: word = 32'($urandom_range(0, 99));
                1: word = -32'($urandom_range(1, 1000));
                2: begin
                    // Neighbors of a power of ten, where the digit count changes.
                    decade = 32'd1;
                    repeat ($urandom_range(0, 9)) decade = decade * 32'd10;
                    word = decade + 32'($urandom_range(0, 2)) - 32'd1;
                end
                3: word = {1'b1, 31'($urandom())};
                default: word = $urandom();
            endcase
            send_number(word, 1'($urandom_range(1)));
            if (n % 97 == 50) begin
                drain_outstanding();
            end
        end
        steady_phase = 1'b0;

        // Wait out the last characters, then allow for anything stray.
        drain_outstanding();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d numbers into %0d characters, signed and unsigned,",
                 numbers_seen, chars_seen);
        $display("covering zero, both range extremes and every digit count.");
        if (error_count == 0 && chars_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
